>>> src/brs_pkg.sv
// brs_pkg: shared types and constants of the binding rate scheduler
// no dependencies
package brs_pkg;

  typedef enum logic [1:0] {
    ACT_BIND  = 2'd0,
    ACT_POLL  = 2'd1,
    ACT_AGE   = 2'd2,
    ACT_DEL   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOT_ELIG = 3'd3,
    ST_READ_ERR = 3'd4
  } status_e;

  localparam int unsigned RegTickStep  = 0;
  localparam int unsigned RegRetxSlow  = 1;
  localparam int unsigned RegRetxFast  = 2;
  localparam int unsigned RegLifetime  = 3;

  typedef struct packed {
    logic [1:0]         action;
    logic [3:0]         slot;
    logic [31:0]        key;
    logic [63:0]        link_id;
    logic [14:0]        rate;
    logic               eligible;
    logic signed [63:0] sample;
    logic               sample_ok;
  } in_item_t;

  typedef struct packed {
    logic               emit;
    logic [31:0]        out_key;
    logic signed [63:0] out_value;
    logic [63:0]        out_link_id;
    logic [3:0]         out_slot;
    logic [2:0]         status;
  } out_item_t;

  // one table entry as stored in memory (valid bits kept apart)
  typedef struct packed {
    logic [31:0] key;
    logic [63:0] link_id;
    logic [15:0] rate;
    logic [63:0] last_value;
    logic [15:0] period_timer;
    logic [15:0] retx_timer;
    logic [7:0]  lifetime;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic [9:0]  tick_step;
    logic [14:0] retx_slow;
    logic [14:0] retx_fast;
    logic [7:0]  lifetime;
  } cfg_t;

endpackage

>>> src/brs_ram.sv
// brs_ram: generic single-port-write, single-port-read ram, registered read
// no dependencies
module brs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> src/brs_cfg_regs.sv
// brs_cfg_regs: apb-style configuration registers
// depends on brs_pkg
module brs_cfg_regs
  import brs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic [1:0] idx;
  logic       wr;

  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (idx)
        2'(RegTickStep): cfg_d.tick_step = pwdata[9:0];
        2'(RegRetxSlow): cfg_d.retx_slow = pwdata[14:0];
        2'(RegRetxFast): cfg_d.retx_fast = pwdata[14:0];
        2'(RegLifetime): cfg_d.lifetime  = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_step <= 10'd20;
      cfg_q.retx_slow <= 15'd1000;
      cfg_q.retx_fast <= 15'd100;
      cfg_q.lifetime  <= 8'd32;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    case (idx)
      2'(RegTickStep): prdata = {22'd0, cfg_q.tick_step};
      2'(RegRetxSlow): prdata = {17'd0, cfg_q.retx_slow};
      2'(RegRetxFast): prdata = {17'd0, cfg_q.retx_fast};
      2'(RegLifetime): prdata = {24'd0, cfg_q.lifetime};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

>>> src/binding_rate_scheduler_core.sv
// binding rate scheduler top level: sequencer walking the entry memory
// depends on brs_pkg, brs_ram, brs_cfg_regs
//
// Usage: input transactions arrive on in_valid_i / in_stall_o with an
// in_item_t payload; each yields exactly one out_item_t on out_valid_o,
// held until out_stall_i is low. Configuration goes through the apb port.
// Sequence: a poll reads its entry in S_POLL_RD and, for a valid slot,
// modifies and writes it back in S_POLL_MOD, then passes S_FIN and S_OUT,
// where its result is loaded into the output register. A bind, an age
// tick and a delete walk every entry through the single read port of the
// entry memory in S_WALK before S_FIN and S_OUT. An ineligible bind skips
// the walk and goes straight from S_IDLE to S_FIN and then S_OUT.
// One transaction is worked on at a time; the next is taken once its
// result sits in the output register, even while that result is stalled,
// as long as the register is free by the time the next result is ready.
// Reset: valid bits clear at once, no clearing pass; configuration returns
// to its defaults. A stalled output holds its payload and blocks only the
// completion of the following transaction.
module binding_rate_scheduler_core
  import brs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_WALK, S_POLL_RD, S_POLL_MOD, S_FIN, S_OUT
  } state_e;

  cfg_t cfg;
  state_e state_q;
  in_item_t item_q;
  logic [TABLE_DEPTH-1:0] valid_q;
  logic [CW-1:0] idx_q;       // walk issue index
  logic          rd_pend_q;   // a read issued last cycle
  logic [AW-1:0] rd_addr_q;
  logic          found_q, free_q;
  logic [AW-1:0] found_idx_q, free_idx_q;
  out_item_t     res_q;
  logic          out_valid_q;
  out_item_t     out_q;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;

  brs_cfg_regs u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  brs_ram #(.Width(EntryW), .Depth(1 << AW)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // poll modify logic
  logic signed [16:0] pt_new, rt_dec;
  logic signed [15:0] rt_cur;
  logic [AW-1:0] slot_a;
  logic slot_ok;
  assign rt_cur = $signed(rdata.retx_timer);
  assign pt_new = $signed({rdata.period_timer[15], rdata.period_timer})
                - $signed({7'd0, cfg.tick_step});
  assign rt_dec = (rt_cur > 0) ? ({rt_cur[15], rt_cur} - $signed({7'd0, cfg.tick_step}))
                               : {rt_cur[15], rt_cur};
  assign slot_a  = AW'(item_q.slot);
  assign slot_ok = ({28'd0, item_q.slot} < 32'(TABLE_DEPTH)) && valid_q[slot_a];

  // age walk modify
  logic [7:0] life_dec;
  assign life_dec = rdata.lifetime - 8'd1;

  // write port and read address
  always_comb begin
    entry_t e;
    logic [15:0] pt, rt;
    e = rdata;
    we = 1'b0;
    waddr = rd_addr_q;
    wdata = rdata;
    if (state_q == S_IDLE) raddr = AW'(in_item_i.slot);
    else if (state_q == S_POLL_RD) raddr = slot_a;
    else raddr = AW'(idx_q);
    pt = pt_new[15:0];
    rt = rt_dec[15:0];
    if (state_q == S_POLL_MOD) begin
      raddr = slot_a;
      waddr = slot_a;
      we = 1'b1;
      if (pt[15]) e.period_timer = rdata.rate; else e.period_timer = pt;
      e.retx_timer = rt;
      if (!pt[15] && !rt[15]) begin
        e.period_timer = pt;
      end else if (item_q.sample_ok) begin
        if (item_q.sample == $signed(rdata.last_value)) begin
          if (!($signed(rt) > 0)) e.retx_timer = {1'b0, cfg.retx_slow};
        end else begin
          e.retx_timer = {1'b0, cfg.retx_fast};
          e.last_value = item_q.sample;
        end
      end
      wdata = e;
    end else if (state_q == S_WALK && rd_pend_q && item_q.action == ACT_AGE
                 && valid_q[rd_addr_q]) begin
      we = 1'b1;
      e.lifetime = life_dec;
      wdata = e;
    end else if (state_q == S_FIN && item_q.action == ACT_BIND && item_q.eligible) begin
      if (found_q) begin
        raddr = found_idx_q;
      end
    end else if (state_q == S_OUT && item_q.action == ACT_BIND) begin
      we = res_q.status == ST_OK;
      waddr = res_q.out_slot[AW-1:0];
      if (found_q) begin
        e = rdata;
        if ({1'b0, item_q.rate} < rdata.rate) e.rate = {1'b0, item_q.rate};
      end else begin
        e.key = item_q.key;
        e.link_id = item_q.link_id;
        e.rate = {1'b0, item_q.rate};
        e.last_value = '0;
        e.period_timer = '0;
        e.retx_timer = '0;
      end
      e.lifetime = cfg.lifetime;
      wdata = e;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      idx_q <= '0;
      rd_pend_q <= 1'b0;
      rd_addr_q <= '0;
      found_q <= 1'b0;
      free_q <= 1'b0;
      found_idx_q <= '0;
      free_idx_q <= '0;
      out_valid_q <= 1'b0;
      item_q <= '0;
      res_q <= '0;
      out_q <= '0;
    end else begin
      rd_pend_q <= (state_q == S_WALK) && (idx_q < CW'(TABLE_DEPTH));
      rd_addr_q <= raddr;
      // output register: loaded on completion, cleared when taken
      if (state_q == S_OUT) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            item_q <= in_item_i;
            found_q <= 1'b0;
            free_q <= 1'b0;
            idx_q <= '0;
            if (in_item_i.action == ACT_POLL) begin
              res_q <= '0;
              state_q <= S_POLL_RD;
            end else if (in_item_i.action == ACT_BIND && !in_item_i.eligible) begin
              res_q <= '{status: ST_NOT_ELIG, default: '0};
              state_q <= S_FIN;
            end else begin
              res_q <= '0;
              state_q <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (idx_q < CW'(TABLE_DEPTH)) begin
            idx_q <= idx_q + 1'b1;
          end
          if (rd_pend_q) begin
            if (valid_q[rd_addr_q]) begin
              case (item_q.action)
                ACT_BIND: if (!found_q && rdata.link_id == item_q.link_id) begin
                  found_q <= 1'b1;
                  found_idx_q <= rd_addr_q;
                end
                ACT_AGE: if (life_dec == 8'd0) valid_q[rd_addr_q] <= 1'b0;
                ACT_DEL: if (rdata.link_id == item_q.link_id)
                  valid_q[rd_addr_q] <= 1'b0;
                default: ;
              endcase
            end else if (!free_q) begin
              free_q <= 1'b1;
              free_idx_q <= rd_addr_q;
            end
          end else if (idx_q == CW'(TABLE_DEPTH)) begin
            state_q <= S_FIN;
          end
        end
        S_POLL_RD: begin
          state_q <= slot_ok ? S_POLL_MOD : S_FIN;
          if (!slot_ok) res_q.status <= ST_EMPTY;
        end
        S_POLL_MOD: begin
          state_q <= S_FIN;
          if (!pt_new[15] && !rt_dec[15]) begin
          end else if (!item_q.sample_ok) begin
            res_q.status <= ST_READ_ERR;
          end else if (item_q.sample != $signed(rdata.last_value)
                       || !($signed(rt_dec[15:0]) > 0)) begin
            res_q <= '{emit: 1'b1, out_key: rdata.key, out_value: item_q.sample,
                       out_link_id: rdata.link_id, out_slot: '0, status: ST_OK};
          end
        end
        S_FIN: begin
          if (item_q.action == ACT_BIND && item_q.eligible) begin
            if (found_q) res_q.out_slot <= 4'(found_idx_q);
            else if (free_q) res_q.out_slot <= 4'(free_idx_q);
            else res_q.status <= ST_FULL;
          end
          if (!out_valid_q || !out_stall_i) state_q <= S_OUT;
        end
        S_OUT: begin
          out_q <= res_q;
          if (item_q.action == ACT_BIND && res_q.status == ST_OK)
            valid_q[res_q.out_slot[AW-1:0]] <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // checks
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o) else $error("stall low while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_item_o)) else $error("out changed");
  a_emit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.emit) |-> (out_item_o.status == ST_OK))
    else $error("emit with bad status");

endmodule
